/* hdl/fsd_pkg.sv */
`default_nettype none
package fsd_pkg;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_MATCH_METRIC    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DITHER_ENABLE   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ALPHA_THRESHOLD = 3'd4;

  // input modes
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  // error words: 8 fraction bits, one per channel
  localparam int ERR_W  = 18;
  localparam int DIST_W = 27;

  // luma weights of the weighted metric
  localparam logic [9:0] W_RED   = 10'd299;
  localparam logic [9:0] W_GREEN = 10'd587;
  localparam logic [9:0] W_BLUE  = 10'd114;

  // corrected value ceiling, 255.0
  localparam logic signed [19:0] CORR_MAX = 20'sd65280;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [2:0] err3_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CORR,
    S_SEARCH,
    S_ERR,
    S_TAIL,
    S_DONE
  } state_t;

  // search control and result
  typedef struct packed {
    logic       start;
    logic       weighted;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } srch_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } srch_rsp_t;

endpackage
`default_nettype wire

/* hdl/fsd_if.sv */
`default_nettype none
interface fsd_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] entry_index;

  modport source (output valid, mode, red, green, blue, alpha, entry_index, input ready);
  modport sink (input valid, mode, red, green, blue, alpha, entry_index, output ready);
endinterface

interface fsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic       frame_end;

  modport source (output valid, color_index, frame_end, input ready);
  modport sink (input valid, color_index, frame_end, output ready);
endinterface
`default_nettype wire

/* hdl/fsd_search.sv */
`default_nettype none
module fsd_search #(
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(PALETTE_SIZE)-1:0]   wr_addr,
  input  wire logic [23:0]                       wr_color,
  input  wire fsd_pkg::srch_req_t                req,
  output fsd_pkg::srch_rsp_t                     rsp
);
  import fsd_pkg::*;

  localparam int PW = $clog2(PALETTE_SIZE);
  localparam logic [PW-1:0] LAST = PW'(PALETTE_SIZE - 1);

  logic [23:0] pal [PALETTE_SIZE];

  logic          busy;
  logic [PW-1:0] cnt;
  logic          weighted;
  logic [7:0]    q_r, q_g, q_b;

  logic          v1, last1;
  logic [PW-1:0] tag1;
  logic [23:0]   rd1;

  logic          v2, last2;
  logic [PW-1:0] tag2;
  logic [23:0]   col2;
  logic [15:0]   sq_r, sq_g, sq_b;

  logic [DIST_W-1:0] best_d;
  logic [PW-1:0]     best_i;
  logic [23:0]       best_col;
  logic              done;

  logic signed [8:0]  dr, dg, db;
  logic signed [17:0] pr, pg, pb;
  logic [DIST_W-1:0]  cand_d;

  // palette memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal[wr_addr] <= wr_color;
    end
    rd1 <= pal[cnt];
  end

  // entry sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + PW'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      weighted <= req.weighted;
      q_r      <= req.red;
      q_g      <= req.green;
      q_b      <= req.blue;
    end
  end

  // channel differences and squares
  always_comb begin
    dr = $signed({1'b0, q_r}) - $signed({1'b0, rd1[23:16]});
    dg = $signed({1'b0, q_g}) - $signed({1'b0, rd1[15:8]});
    db = $signed({1'b0, q_b}) - $signed({1'b0, rd1[7:0]});
    pr = dr * dr;
    pg = dg * dg;
    pb = db * db;
  end

  always_comb begin
    if (weighted) begin
      cand_d = DIST_W'(sq_r) * DIST_W'(W_RED) + DIST_W'(sq_g) * DIST_W'(W_GREEN)
             + DIST_W'(sq_b) * DIST_W'(W_BLUE);
    end else begin
      cand_d = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= busy;
      v2   <= v1;
      done <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= (cnt == LAST);
    tag1  <= cnt;
    last2 <= last1;
    tag2  <= tag1;
    col2  <= rd1;
    sq_r  <= pr[15:0];
    sq_g  <= pg[15:0];
    sq_b  <= pb[15:0];
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (req.start) begin
      best_d <= '1;
      best_i <= '0;
    end else if (v2 && cand_d < best_d) begin
      best_d   <= cand_d;
      best_i   <= tag2;
      best_col <= col2;
    end
  end

  assign rsp.done  = done;
  assign rsp.index = 8'(best_i);
  assign rsp.red   = best_col[23:16];
  assign rsp.green = best_col[15:8];
  assign rsp.blue  = best_col[7:0];

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy && !v1 && !v2)
    else $error("search started while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v2) && $past(last2))
    else $error("search done without last entry");
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == LAST && !req.start) |=> !busy)
    else $error("sweep ran past last entry");
`endif

endmodule
`default_nettype wire

/* hdl/floyd_steinberg_palette_dither.sv */
`default_nettype none
// Palette dither: maps raster-order RGBA pixels to indices of a palette of up to
// 256 colors, optionally with Floyd-Steinberg error diffusion. Load the palette
// (mode 1 requests) before any pixel. The nearest-color sweep of an opaque pixel
// reads one palette memory entry per cycle; a transparent pixel skips the sweep.
// The last pixel of a row below which error is carried passes through an extra
// tail state for a second line memory write. Results leave through an output
// register, so the next request is taken while one waits.
// Write configuration only while the block is idle.
module floyd_steinberg_palette_dither #(
  parameter int MAX_WIDTH    = 1024,
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fsd_pix_if.sink                          pix,
  fsd_res_if.source                        res,
  input  wire logic                        cfg_write,
  input  wire logic [fsd_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [fsd_pkg::CFG_DW-1:0]  cfg_data
);
  import fsd_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > 11) ? XW + 1 : 11;
  localparam int PW = $clog2(PALETTE_SIZE);

  // configuration
  logic        match_metric;
  logic        dither_enable;
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  alpha_threshold;

  state_t state, state_next;

  // frame position
  logic [XW-1:0] column_count;
  logic [15:0]   row_count;

  // pixel held while at work
  logic [2:0][7:0] comp;
  logic            opaque;
  logic [XW-1:0]   x;
  logic            first_row, last_row, last_col;
  logic [2:0][15:0] corr;

  err3_t right_error, pending_below_left, pending_below;

  // line memory
  err3_t         line_mem [MAX_WIDTH];
  err3_t         line_rd;
  logic          lm_we;
  logic [XW-1:0] lm_addr;
  err3_t         lm_wdata;

  srch_req_t sreq;
  srch_rsp_t srsp;

  logic pix_accept, pal_write, out_load;
  logic [CW-1:0] w_raw, w_eff;
  logic in_last_col, in_last_row;

  err3_t c7, c3, c5, c1;
  logic [2:0][7:0] pal_col;
  logic [7:0] idx;
  logic [2:0][15:0] corr_calc;

  function automatic err_t contrib(err_t e, logic [2:0] k);
    logic signed [20:0] ew;
    logic signed [20:0] kk;
    logic signed [20:0] p;
    ew = {{3{e[ERR_W-1]}}, e};
    kk = $signed({18'b0, k});
    p  = ew * kk;
    return err_t'(p >>> 4);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_metric    <= 1'b1;
      dither_enable   <= 1'b1;
      image_width     <= 11'd1024;
      image_height    <= 16'd1;
      alpha_threshold <= 8'd16;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_MATCH_METRIC:    match_metric    <= cfg_data[0];
        REG_DITHER_ENABLE:   dither_enable   <= cfg_data[0];
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[15:0];
        REG_ALPHA_THRESHOLD: alpha_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // row geometry for the arriving pixel
  always_comb begin
    w_raw = CW'(image_width);
    if (w_raw == '0) begin
      w_eff = CW'(1);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    in_last_col = (CW'(column_count) + CW'(1)) >= w_eff;
    in_last_row = (image_height == 16'd0) || (row_count >= image_height - 16'd1);
  end

  assign pix_accept = pix.valid && pix.ready && (pix.mode == MODE_PIXEL);
  assign pal_write  = pix.valid && pix.ready && (pix.mode == MODE_PALETTE)
                   && (9'(pix.entry_index) < 9'(PALETTE_SIZE));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (pix_accept) state_next = S_READ;
      S_READ:   state_next = S_CORR;
      S_CORR:   state_next = opaque ? S_SEARCH : S_ERR;
      S_SEARCH: if (srsp.done) state_next = S_ERR;
      S_ERR:    state_next = (last_col && !last_row) ? S_TAIL : S_DONE;
      S_TAIL:   state_next = S_DONE;
      S_DONE:   if (!res.valid || res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // error contributions of the current pixel
  always_comb begin
    pal_col = {srsp.red, srsp.green, srsp.blue};
    idx     = opaque ? srsp.index : 8'd0;
    for (int k = 0; k < 3; k++) begin
      err_t e;
      e = $signed({2'b00, corr[k]}) - $signed({2'b00, pal_col[k], 8'h00});
      if (opaque && dither_enable) begin
        c7[k] = contrib(e, 3'd7);
        c3[k] = contrib(e, 3'd3);
        c5[k] = contrib(e, 3'd5);
        c1[k] = contrib(e, 3'd1);
      end else begin
        c7[k] = '0;
        c3[k] = '0;
        c5[k] = '0;
        c1[k] = '0;
      end
    end
  end

  // corrected value, clamped to 0..255.0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [19:0] v;
      v = $signed({4'b0, comp[k], 8'h00}) + 20'(right_error[k])
        + (first_row ? 20'sd0 : 20'(line_rd[k]));
      if (!dither_enable) begin
        corr_calc[k] = {comp[k], 8'h00};
      end else if (v < 20'sd0) begin
        corr_calc[k] = 16'd0;
      end else if (v > CORR_MAX) begin
        corr_calc[k] = CORR_MAX[15:0];
      end else begin
        corr_calc[k] = v[15:0];
      end
    end
  end

  // outputs of the sequencer
  always_comb begin
    pix.ready     = (state == S_IDLE);
    sreq.start    = (state == S_CORR) && opaque;
    sreq.weighted = match_metric;
    sreq.red      = corr_calc[2][15:8];
    sreq.green    = corr_calc[1][15:8];
    sreq.blue     = corr_calc[0][15:8];
    out_load      = (state == S_DONE) && (!res.valid || res.ready);
    lm_we         = 1'b0;
    lm_addr       = x;
    lm_wdata      = pending_below_left;
    case (state)
      S_ERR: begin
        lm_we   = !last_row && (x != '0);
        lm_addr = x - XW'(1);
        for (int k = 0; k < 3; k++) begin
          lm_wdata[k] = pending_below_left[k] + c3[k];
        end
      end
      S_TAIL: begin
        lm_we = 1'b1;
      end
      default: ;
    endcase
  end

  // line memory, registered read
  always_ff @(posedge clk) begin
    if (lm_we) begin
      line_mem[lm_addr] <= lm_wdata;
    end
    line_rd <= line_mem[x];
  end

  fsd_search #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (pal_write),
    .wr_addr  (pix.entry_index[PW-1:0]),
    .wr_color ({pix.red, pix.green, pix.blue}),
    .req      (sreq),
    .rsp      (srsp)
  );

  // pixel capture; channel 2 is red, 0 is blue
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      comp      <= {pix.red, pix.green, pix.blue};
      opaque    <= pix.alpha > alpha_threshold;
      x         <= column_count;
      first_row <= (row_count == 16'd0);
      last_row  <= in_last_row;
      last_col  <= in_last_col;
    end
    if (state == S_CORR) begin
      corr <= corr_calc;
    end
  end

  // error carry and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      right_error        <= '0;
      pending_below_left <= '0;
      pending_below      <= '0;
      column_count       <= '0;
      row_count          <= '0;
    end else begin
      case (state)
        S_ERR: begin
          right_error <= c7;
          if (!last_row) begin
            for (int k = 0; k < 3; k++) begin
              pending_below_left[k] <= pending_below[k] + c5[k];
            end
            pending_below <= c1;
          end
          if (last_col) begin
            column_count <= '0;
            row_count    <= last_row ? 16'd0 : row_count + 16'd1;
          end else begin
            column_count <= x + XW'(1);
          end
        end
        S_DONE: begin
          if (last_col) begin
            right_error        <= '0;
            pending_below_left <= '0;
            pending_below      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // payload loads together with valid, held while a result waits
  always_ff @(posedge clk) begin
    if (out_load) begin
      res.color_index <= idx;
      res.frame_end   <= last_col && last_row;
    end
  end

`ifndef SYNTH
  a_pixel_starts: assert property (@(posedge clk) disable iff (rst)
    pix_accept |=> state == S_READ)
    else $error("accepted pixel not started");
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    srsp.done |-> state == S_SEARCH)
    else $error("search result outside search state");
  a_no_write_last_row: assert property (@(posedge clk) disable iff (rst)
    lm_we |-> !last_row)
    else $error("line memory written on last row");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> res.valid)
    else $error("result not presented");
`endif

endmodule
`default_nettype wire
